// ===== rtl/cidh_pkg.sv =====
// Package: constants, codes and the hash step for the connection-ID table.
package cidh_pkg;
  localparam int BUCKETS_DEF = 4096;
  localparam int WAYS_DEF = 4;
  localparam int MAX_CID_DEF = 20;
  localparam int INDEX_BITS = 12;
  localparam int HASH_MULT = 31;
  localparam int LEN_W = 5;
  localparam int CID_W = 160;
  localparam int HANDLE_W = 16;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // one stored slot: ID (byte 0 in top bits), length, handle, used mark
  typedef struct packed {
    logic                used;
    logic [LEN_W-1:0]    len;
    logic [CID_W-1:0]    cid;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  // h*31 + byte, 32-bit wrap
  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    hash_step = (h << 5) - h + {24'd0, b};
  endfunction
endpackage

// ===== rtl/cidh_slot_ram.sv =====
// Slot memory: one write port, one registered read port.
module cidh_slot_ram #(
  parameter int DEPTH = 16384,
  parameter int AW = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  cidh_pkg::slot_t   wdata,
  input  logic [AW-1:0]     raddr,
  output cidh_pkg::slot_t   rdata
);
  import cidh_pkg::*;
  slot_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/connection_id_hash_table.sv =====
// Top level: connection-ID hash table with lookup, head insert and delete.
// Channels: s_axis carries one operation per word; m_axis returns one result
// word per operation. tuser on s_axis holds mode; tdata packs cid_length,
// cid_bytes_first, cid_bytes_second, cid_bytes_third, conn_handle.
// m_axis tuser holds status; tdata packs found_handle, bucket_index.
// Flow per item: hash one byte a cycle (up to 20 bytes), then read the WAYS
// slots of the bucket one a cycle from the slot memory (one registered read
// port), then for insert or delete shift the bucket list one slot a cycle
// through the single write port. The next item is taken once the result
// sits in the output register.
// Reset: a clearing pass writes every slot unused, one slot a cycle,
// over all BUCKETS*WAYS slots; s_axis_tready stays low until it ends.
// A stalled receiver holds the result; the block then accepts one more item
// and works on it, waiting to publish until the output register is free.
module connection_id_hash_table #(
  parameter int BUCKETS = cidh_pkg::BUCKETS_DEF,
  parameter int WAYS = cidh_pkg::WAYS_DEF,
  parameter int MAX_CID_BYTES = cidh_pkg::MAX_CID_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [4:0] cid_length, [68:5] first, [132:69] second, [164:133] third,
  // [180:165] conn_handle, rest zero
  input  logic [183:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,  // [1:0] mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // [15:0] found_handle, [27:16] bucket_index
  output logic [1:0]   m_axis_tuser   // [1:0] status
);
  import cidh_pkg::*;

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int AW = $clog2(SLOTS);
  localparam int BW = $clog2(BUCKETS);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);

  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_HASH = 3'd2,
                         S_READ = 3'd3, S_SHIFT = 3'd4, S_DONE = 3'd5;

  logic [2:0] state;
  logic [1:0] mode;
  logic [LEN_W-1:0] len, cnt;
  logic [CID_W-1:0] cid;
  logic [HANDLE_W-1:0] handle;
  logic [31:0] h;
  logic [BW-1:0] bucket;
  logic [CW-1:0] rd_i, used_n, match, sh_i;
  logic rd_v;
  logic [CW-1:0] rd_w;
  slot_t buf_s [WAYS];
  logic [AW-1:0] clr_a;

  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  slot_t ram_wd, ram_rd;

  cidh_slot_ram #(.DEPTH(SLOTS), .AW(AW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd));

  // masked input: bytes past the length cleared
  logic [LEN_W-1:0] in_len;
  logic [CID_W-1:0] in_cid, keep;
  always_comb begin
    in_len = s_axis_tdata[4:0];
    if (32'(in_len) > MAX_CID_BYTES) in_len = LEN_W'(MAX_CID_BYTES);
    in_cid = {s_axis_tdata[68:5], s_axis_tdata[132:69], s_axis_tdata[164:133]};
    keep = '0;
    for (int i = 0; i < 20; i++)
      if (i < 32'(in_len)) keep[CID_W-1-8*i -: 8] = 8'hFF;
  end

  logic [AW-1:0] base;
  assign base = AW'(bucket) * AW'(WAYS);

  logic out_busy;
  assign out_busy = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  slot_t new_s;
  always_comb begin
    new_s.used = 1'b1; new_s.len = len; new_s.cid = cid; new_s.handle = handle;
  end

  // write port: clear pass, or shift step
  always_comb begin
    ram_we = 1'b0; ram_wa = clr_a; ram_wd = '0;
    if (state == S_CLR) ram_we = 1'b1;
    else if (state == S_SHIFT) begin
      ram_we = 1'b1;
      ram_wa = base + AW'(sh_i);
      if (mode == MODE_INSERT)
        ram_wd = (sh_i == '0) ? new_s : buf_s[WW'(sh_i - 1'b1)];
      else
        ram_wd = (sh_i + 1'b1 < used_n) ? buf_s[WW'(sh_i + 1'b1)] : '0;
    end
  end
  assign ram_ra = base + AW'(rd_i);

  logic hit;
  assign hit = ram_rd.used && ram_rd.len == len && ram_rd.cid == cid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_a <= '0; m_axis_tvalid <= 1'b0; rd_v <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_a <= clr_a + 1'b1;
          if (32'(clr_a) == SLOTS - 1) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          mode <= s_axis_tuser; len <= in_len; cid <= in_cid & keep;
          handle <= s_axis_tdata[180:165]; h <= '0; cnt <= '0;
          state <= S_HASH;
        end
        S_HASH: begin
          if (cnt == len) begin
            bucket <= BW'(h & 32'(BUCKETS - 1));
            rd_i <= '0; rd_v <= 1'b0; used_n <= '0; match <= CW'(WAYS);
            state <= S_READ;
          end else begin
            h <= hash_step(h, cid[CID_W-1-8*cnt -: 8]);
            cnt <= cnt + 1'b1;
          end
        end
        S_READ: begin
          if (32'(rd_i) < WAYS) begin
            rd_i <= rd_i + 1'b1; rd_w <= rd_i;
          end
          rd_v <= (32'(rd_i) < WAYS);
          if (rd_v) begin
            buf_s[WW'(rd_w)] <= ram_rd;
            if (ram_rd.used) used_n <= used_n + 1'b1;
            if (hit && match == CW'(WAYS)) match <= rd_w;
            if (32'(rd_w) == WAYS - 1) begin
              state <= S_DONE;
              // slot w+1 needs old slot w; walk from the tail down for insert
              if (mode == MODE_INSERT && 32'(used_n + CW'(ram_rd.used)) < WAYS) begin
                sh_i <= used_n + CW'(ram_rd.used); state <= S_SHIFT;
              end
              if (mode == MODE_DELETE && (match != CW'(WAYS) || hit)) begin
                sh_i <= (match != CW'(WAYS)) ? match : rd_w; state <= S_SHIFT;
                used_n <= used_n + CW'(ram_rd.used);
              end
            end
          end
        end
        S_SHIFT: begin
          if (mode == MODE_INSERT) begin
            if (sh_i == '0) state <= S_DONE; else sh_i <= sh_i - 1'b1;
          end else begin
            if (sh_i + 1'b1 >= used_n) state <= S_DONE; else sh_i <= sh_i + 1'b1;
          end
        end
        S_DONE: if (!out_busy) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= '0;
          m_axis_tdata[27:16] <= INDEX_BITS'(bucket);
          m_axis_tuser <= ST_MISS;
          case (mode)
            MODE_LOOKUP, MODE_DELETE: if (match != CW'(WAYS)) begin
              m_axis_tuser <= ST_OK;
              m_axis_tdata[15:0] <= buf_s[WW'(match)].handle;
            end
            MODE_INSERT: m_axis_tuser <= (32'(used_n) >= WAYS) ? ST_FULL : ST_OK;
            default: ;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !m_axis_tvalid) else $error("result during clear");
endmodule

// ===== bench/connection_id_hash_table_test.sv =====
// Testbench for the connection-ID hash table: directed and random operations, scoreboard check.
class cid_table_scoreboard;
  localparam int NSLOT = cidh_pkg::BUCKETS_DEF * cidh_pkg::WAYS_DEF;
  logic [159:0] tab_cid[NSLOT];
  logic [4:0]   tab_len[NSLOT];
  logic [15:0]  tab_handle[NSLOT];
  int           fill[cidh_pkg::BUCKETS_DEF];
  logic [29:0]  pending[$];  // {status, bucket, handle}
  int           errors;

  function new();
    for (int b = 0; b < cidh_pkg::BUCKETS_DEF; b++) fill[b] = 0;
    errors = 0;
  endfunction

  // predict the result of one accepted operation and update the table copy
  function void note_op(logic [1:0] mode, logic [4:0] len_in, logic [159:0] cid_in,
                        logic [15:0] handle);
    logic [4:0]   len;
    logic [159:0] cid;
    logic [31:0]  h;
    int           bkt, base, hit;
    logic [1:0]   st;
    logic [15:0]  got;
    len = (len_in > 5'd20) ? 5'd20 : len_in;
    cid = cid_in & ~({160{1'b1}} >> (8 * len));
    h = 0;
    for (int i = 0; i < len; i++) h = h * 32'd31 + {24'd0, cid[159-8*i -: 8]};
    bkt = h % cidh_pkg::BUCKETS_DEF;
    base = bkt * cidh_pkg::WAYS_DEF;
    hit = -1;
    for (int w = 0; w < fill[bkt]; w++)
      if (hit < 0 && tab_len[base+w] == len && tab_cid[base+w] == cid) hit = w;
    st = cidh_pkg::ST_MISS;
    got = 16'd0;
    case (mode)
      cidh_pkg::MODE_LOOKUP: begin
        if (hit >= 0) begin
          st = cidh_pkg::ST_OK;
          got = tab_handle[base+hit];
        end
      end
      cidh_pkg::MODE_INSERT: begin
        if (fill[bkt] >= cidh_pkg::WAYS_DEF) st = cidh_pkg::ST_FULL;
        else begin
          for (int w = fill[bkt]; w > 0; w--) begin
            tab_cid[base+w] = tab_cid[base+w-1];
            tab_len[base+w] = tab_len[base+w-1];
            tab_handle[base+w] = tab_handle[base+w-1];
          end
          tab_cid[base] = cid;
          tab_len[base] = len;
          tab_handle[base] = handle;
          fill[bkt]++;
          st = cidh_pkg::ST_OK;
        end
      end
      cidh_pkg::MODE_DELETE: begin
        if (hit >= 0) begin
          st = cidh_pkg::ST_OK;
          got = tab_handle[base+hit];
          for (int w = hit; w + 1 < fill[bkt]; w++) begin
            tab_cid[base+w] = tab_cid[base+w+1];
            tab_len[base+w] = tab_len[base+w+1];
            tab_handle[base+w] = tab_handle[base+w+1];
          end
          fill[bkt]--;
        end
      end
      default: ;
    endcase
    pending.push_back({st, bkt[11:0], got});
  endfunction

  function void check_result(logic [1:0] st, logic [11:0] bkt, logic [15:0] got);
    logic [29:0] exp;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word: status %0d bucket %0d handle %h",
                                 st, bkt, got);
      return;
    end
    exp = pending.pop_front();
    if (exp != {st, bkt, got}) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected status %0d bucket %0d handle %h, got %0d %0d %h",
                 exp[29:28], exp[27:16], exp[15:0], st, bkt, got);
    end
  endfunction
endclass

module connection_id_hash_table_test;
  import cidh_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;  // covers the post-reset clearing pass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  cid_table_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  quiet_phase = 1'b0;   // when set, neither side inserts gaps
  logic [159:0] pool[16];

  always #1 clk = ~clk;

  connection_id_hash_table dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if (quiet_phase) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
  endfunction

  // monitor: check results first, then predict the word taken this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata[27:16], m_axis_tdata[15:0]);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_op(s_axis_tuser, s_axis_tdata[4:0],
                   {s_axis_tdata[68:5], s_axis_tdata[132:69], s_axis_tdata[164:133]},
                   s_axis_tdata[180:165]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls
  initial begin
    @(negedge clk);
    forever begin
      m_axis_tready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      if (gap_len() > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap_len() + 1) @(negedge clk);
      end
    end
  end

  // present one operation word and hold it until taken
  // cid holds byte 0 in its top bits; it goes out as first, second, third
  task automatic send_op(logic [1:0] mode, logic [4:0] len, logic [159:0] cid,
                         logic [15:0] handle);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tuser = mode;
    s_axis_tdata = {3'd0, handle, cid[31:0], cid[95:32], cid[159:96], len};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // colliding two-byte IDs: 31*b0 + b1 = 503, low bytes random garbage
  function automatic logic [159:0] collide_id(int k);
    logic [159:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom};
    v[159:144] = {8'(8 + k), 8'(503 - 31 * (8 + k))};
    return v;
  endfunction

  initial begin
    logic [159:0] rnd;
    logic [1:0]   m;
    int           k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty ID, collisions up to a full bucket, deletes, odd modes
    quiet_phase = 1'b1;
    send_op(MODE_LOOKUP, 5'd0, '0, 16'h0000);
    send_op(MODE_INSERT, 5'd0, {160{1'b1}}, 16'hFFFF);
    send_op(MODE_LOOKUP, 5'd0, '0, 16'h1234);
    for (int i = 0; i < 5; i++) send_op(MODE_INSERT, 5'd2, collide_id(i), 16'(16'h100 + i));
    quiet_phase = 1'b0;
    send_op(MODE_LOOKUP, 5'd2, collide_id(0), 16'h0);   // trailing bytes differ
    send_op(MODE_LOOKUP, 5'd2, collide_id(4), 16'h0);   // refused, so a miss
    send_op(MODE_DELETE, 5'd2, collide_id(2), 16'h0);   // middle of the list
    send_op(MODE_LOOKUP, 5'd2, collide_id(2), 16'h0);
    send_op(MODE_LOOKUP, 5'd2, collide_id(1), 16'h0);
    send_op(MODE_INSERT, 5'd2, collide_id(3), 16'hBEEF); // duplicate
    send_op(MODE_LOOKUP, 5'd2, collide_id(3), 16'h0);
    send_op(MODE_DELETE, 5'd2, collide_id(7), 16'h0);   // miss
    send_op(2'd3, 5'd2, collide_id(0), 16'h5555);        // unknown mode
    send_op(MODE_INSERT, 5'd31, {160{1'b1}}, 16'hA5A5);  // length saturates
    send_op(MODE_LOOKUP, 5'd20, {160{1'b1}}, 16'h0);
    send_op(MODE_INSERT, 5'd20, '0, 16'h0000);
    send_op(MODE_DELETE, 5'd25, '0, 16'hFFFF);
    send_op(MODE_DELETE, 5'd0, '0, 16'h0);

    // random: mostly a small ID pool so entries get hit, some fresh IDs
    for (int i = 0; i < 16; i++)
      pool[i] = (i < 9) ? collide_id(i) : {$urandom, $urandom, $urandom, $urandom, $urandom};
    for (int n = 0; n < 450; n++) begin
      if (n % 150 == 100) quiet_phase = 1'b1;
      if (n % 150 == 130) quiet_phase = 1'b0;
      k = $urandom_range(0, 99);
      m = (k < 40) ? MODE_LOOKUP : (k < 70) ? MODE_INSERT : (k < 95) ? MODE_DELETE : 2'd3;
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
        send_op(m, 5'($urandom_range(0, 31)), rnd, 16'($urandom));
      end else begin
        k = $urandom_range(0, 15);
        if (k < 9) begin
          rnd[159:144] = pool[k][159:144];
          send_op(m, 5'd2, rnd, 16'($urandom));
        end else begin
          send_op(m, 5'(4 + k), pool[k], 16'($urandom));
        end
      end
    end
    s_axis_tvalid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
